FILE: hw/rtl/mltfd_pkg.sv
// ----------------------------------------------------------------------------
// mltfd_pkg
// Shared types and constants for the magic/length/tail frame decoder.
// ----------------------------------------------------------------------------
package mltfd_pkg;

   // field widths fixed by the frame layout
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned TYPE_W   = 16;
   localparam int unsigned IDENT_W  = 64;
   localparam int unsigned LENGTH_W = 32;
   localparam int unsigned PLEN_W   = 16;
   localparam int unsigned CNT_W    = 4;
   localparam int unsigned KIND_W   = 3;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   // header byte positions after the magic byte
   localparam logic [CNT_W-1:0] TYPE_END    = 4'd2;
   localparam logic [CNT_W-1:0] IDENT_END   = 4'd10;
   localparam logic [CNT_W-1:0] HEADER_LAST = 4'd13;

   localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hFF;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAGIC   = 2'd0,
      CSR_TAIL    = 2'd1,
      CSR_MAX_LEN = 2'd2
   } csr_index_type;

   // parser phase
   typedef enum logic [1:0] {
      PH_HUNT,
      PH_HEADER,
      PH_PAYLOAD,
      PH_TAIL
   } phase_type;

   // result kind codes
   typedef enum logic [KIND_W-1:0] {
      K_HEADER    = 3'd0,
      K_PAYLOAD   = 3'd1,
      K_OK        = 3'd2,
      K_BAD_MAGIC = 3'd3,
      K_BAD_TAIL  = 3'd4,
      K_TOO_LONG  = 3'd5
   } kind_type;

   // one registered input word
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
   } in_word_type;

   // one result word
   typedef struct packed {
      kind_type           kind;
      logic [TYPE_W-1:0]  msg_type;
      logic [IDENT_W-1:0] user_ident;
      logic [PLEN_W-1:0]  payload_len;
      logic [BYTE_W-1:0]  payload_byte;
      logic               last_payload;
   } result_type;

   // configuration values seen by the parser
   typedef struct packed {
      logic [BYTE_W-1:0] magic_byte;
      logic [BYTE_W-1:0] tail_byte;
      logic [PLEN_W-1:0] max_payload_len;
   } cfg_type;

endpackage

FILE: hw/rtl/magic_length_tail_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// magic_length_tail_frame_decoder_core
// Parses magic / type / user id / length / payload / tail frames from a
// byte stream, one byte per word, giving header, payload and status words.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------
//   req     | in        | req_valid/req_ready   | data_byte
//   rsp     | out       | rsp_valid/rsp_ready   | kind, msg_type, user_ident,
//           |           |                       | payload_len, payload_byte,
//           |           |                       | last_payload
//   csr     | in        | csr_valid/csr_ready   | csr_index, csr_data
//
// One byte per cycle sustained while rsp is drained; an accepted byte passes
// through the input register, then through the parser into the result reg.
// Nothing limits the rate beyond the result register being drained.
// Synchronous active-high reset clears state and sets max_payload_len to 65535.
// A stalled rsp holds its word; req keeps accepting while the input register
// can move forward, and csr is always ready.
// ----------------------------------------------------------------------------
module magic_length_tail_frame_decoder_core #(
   parameter int unsigned LEN_WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [mltfd_pkg::BYTE_W-1:0]     req_data_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output mltfd_pkg::kind_type              rsp_kind,
   output logic [mltfd_pkg::TYPE_W-1:0]     rsp_msg_type,
   output logic [mltfd_pkg::IDENT_W-1:0]    rsp_user_ident,
   output logic [mltfd_pkg::PLEN_W-1:0]     rsp_payload_len,
   output logic [mltfd_pkg::BYTE_W-1:0]     rsp_payload_byte,
   output logic                             rsp_last_payload,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mltfd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mltfd_pkg::CSR_DATA_W-1:0] csr_data
);
   import mltfd_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   in_word_type in_word;
   result_type  result;
   result_type  rsp_word;
   logic        out_free;
   logic        take;
   logic        emit;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MAGIC:   cfg_in.magic_byte      = csr_data[BYTE_W-1:0];
            CSR_TAIL:    cfg_in.tail_byte       = csr_data[BYTE_W-1:0];
            CSR_MAX_LEN: cfg_in.max_payload_len = csr_data[PLEN_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic_byte      <= '0;
         cfg_ff.tail_byte       <= '0;
         cfg_ff.max_payload_len <= '1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // a byte moves into the parser when the result slot can take its word
   assign take = in_word.valid && out_free;

   mltfd_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .take          (take),
      .word          (in_word)
   );

   mltfd_parser #(
      .LEN_WIDTH (LEN_WIDTH)
   ) u_parser (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .word   (in_word),
      .take   (take),
      .emit   (emit),
      .result (result)
   );

   mltfd_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (take && emit),
      .result    (result),
      .free      (out_free),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   // result fields onto their ports
   assign rsp_kind         = rsp_word.kind;
   assign rsp_msg_type     = rsp_word.msg_type;
   assign rsp_user_ident   = rsp_word.user_ident;
   assign rsp_payload_len  = rsp_word.payload_len;
   assign rsp_payload_byte = rsp_word.payload_byte;
   assign rsp_last_payload = rsp_word.last_payload;

endmodule

FILE: hw/rtl/mltfd_in_stage.sv
// ----------------------------------------------------------------------------
// mltfd_in_stage
// Input register: holds one stream byte until the parser takes it.
// ----------------------------------------------------------------------------
module mltfd_in_stage (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [mltfd_pkg::BYTE_W-1:0] req_data_byte,
   input  logic                         take,
   output mltfd_pkg::in_word_type       word
);
   import mltfd_pkg::*;

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] data_ff, data_in;

   // refill whenever empty or draining this cycle
   assign req_ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (req_ready) begin
         valid_in = req_valid;
         data_in  = req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign word.valid = valid_ff;
   assign word.data  = data_ff;

endmodule

FILE: hw/rtl/mltfd_parser.sv
// ----------------------------------------------------------------------------
// mltfd_parser
// Frame state machine: header shift registers, payload count and the
// result decode for the byte taken this cycle.
// ----------------------------------------------------------------------------
module mltfd_parser #(
   parameter int unsigned LEN_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mltfd_pkg::cfg_type     cfg,
   input  mltfd_pkg::in_word_type word,
   input  logic                   take,
   output logic                   emit,
   output mltfd_pkg::result_type  result
);
   import mltfd_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [CNT_W-1:0]       header_count_ff, header_count_in;
   logic [TYPE_W-1:0]      type_shift_ff, type_shift_in;
   logic [IDENT_W-1:0]     ident_shift_ff, ident_shift_in;
   logic [LENGTH_W-1:0]    length_shift_ff, length_shift_in;
   logic [LEN_WIDTH-1:0]   bytes_remaining_ff, bytes_remaining_in;

   logic [BYTE_W-1:0]   b;
   logic [LENGTH_W-1:0] length_next;
   logic                len_over;
   logic                too_long;
   logic                header_done;
   logic                last;

   assign b           = word.data & BYTE_MASK;
   assign length_next = {length_shift_ff[LENGTH_W-BYTE_W-1:0], b};
   assign header_done = (phase_ff == PH_HEADER) && (header_count_ff == HEADER_LAST);
   assign last        = (bytes_remaining_ff <= LEN_WIDTH'(1));

   // length that does not fit the payload counter
   generate
      if (LEN_WIDTH < LENGTH_W) begin : g_len_check
         assign len_over = |length_next[LENGTH_W-1:LEN_WIDTH];
      end else begin : g_len_full
         assign len_over = 1'b0;
      end
   endgenerate

   assign too_long = (length_next > {{(LENGTH_W-PLEN_W){1'b0}}, cfg.max_payload_len})
                     || len_over;

   // next state
   always_comb begin
      phase_in           = phase_ff;
      header_count_in    = header_count_ff;
      type_shift_in      = type_shift_ff;
      ident_shift_in     = ident_shift_ff;
      length_shift_in    = length_shift_ff;
      bytes_remaining_in = bytes_remaining_ff;
      if (take) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (header_count_ff < TYPE_END) begin
                  type_shift_in = {type_shift_ff[TYPE_W-BYTE_W-1:0], b};
               end else if (header_count_ff < IDENT_END) begin
                  ident_shift_in = {ident_shift_ff[IDENT_W-BYTE_W-1:0], b};
               end else begin
                  length_shift_in = length_next;
               end
               header_count_in = header_count_ff + CNT_W'(1);
               if (header_done) begin
                  header_count_in = '0;
                  if (too_long) begin
                     phase_in = PH_HUNT;
                  end else begin
                     bytes_remaining_in = length_next[LEN_WIDTH-1:0];
                     phase_in = (length_next == '0) ? PH_TAIL : PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               if (last) begin
                  bytes_remaining_in = '0;
                  phase_in           = PH_TAIL;
               end else begin
                  bytes_remaining_in = bytes_remaining_ff - LEN_WIDTH'(1);
               end
            end
            PH_TAIL: begin
               phase_in = PH_HUNT;
            end
            default: begin
               phase_in = PH_HUNT;
               if (b == cfg.magic_byte) begin
                  phase_in        = PH_HEADER;
                  header_count_in = '0;
                  type_shift_in   = '0;
                  ident_shift_in  = '0;
                  length_shift_in = '0;
               end
            end
         endcase
      end
   end

   // result for the byte being taken
   always_comb begin
      emit   = 1'b0;
      result = '0;
      result.kind = K_BAD_MAGIC;
      unique case (phase_ff)
         PH_HEADER: begin
            if (header_done) begin
               emit = 1'b1;
               if (too_long) begin
                  result.kind = K_TOO_LONG;
               end else begin
                  result.kind        = K_HEADER;
                  result.msg_type    = type_shift_ff;
                  result.user_ident  = ident_shift_ff;
                  result.payload_len = length_next[PLEN_W-1:0];
               end
            end
         end
         PH_PAYLOAD: begin
            emit                = 1'b1;
            result.kind         = K_PAYLOAD;
            result.payload_byte = b;
            result.last_payload = last;
         end
         PH_TAIL: begin
            emit        = 1'b1;
            result.kind = (b == cfg.tail_byte) ? K_OK : K_BAD_TAIL;
         end
         default: begin
            emit = (b != cfg.magic_byte);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_HUNT;
         header_count_ff    <= '0;
         type_shift_ff      <= '0;
         ident_shift_ff     <= '0;
         length_shift_ff    <= '0;
         bytes_remaining_ff <= '0;
      end else begin
         phase_ff           <= phase_in;
         header_count_ff    <= header_count_in;
         type_shift_ff      <= type_shift_in;
         ident_shift_ff     <= ident_shift_in;
         length_shift_ff    <= length_shift_in;
         bytes_remaining_ff <= bytes_remaining_in;
      end
   end

endmodule

FILE: hw/rtl/mltfd_out_stage.sv
// ----------------------------------------------------------------------------
// mltfd_out_stage
// Result register: holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module mltfd_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  mltfd_pkg::result_type result,
   output logic                  free,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output mltfd_pkg::result_type rsp_word
);
   import mltfd_pkg::*;

   logic       valid_ff, valid_in;
   result_type word_ff, word_in;

   // slot is free when empty or being drained
   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (free) begin
         valid_in = load;
         word_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule
